>>> src/length_prefixed_message_ring_core_assert.svh
// ----------------------------------------------------------------------------
// Length-prefixed message ring assertion macros
// Shared property forms used by the ring core checks.
// ----------------------------------------------------------------------------
`ifndef LENGTH_PREFIXED_MESSAGE_RING_CORE_ASSERT_SVH
`define LENGTH_PREFIXED_MESSAGE_RING_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LPMR_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define LPMR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> src/lpmr_pkg.sv
// ----------------------------------------------------------------------------
// Length-prefixed message ring package
// Shared types and constants of the message ring core.
// ----------------------------------------------------------------------------
package lpmr_pkg;

   localparam int RING_BYTES_DEF = 4096;
   localparam int HDR_BYTES      = 4;
   localparam int LEN_W          = 12;
   localparam int BYTE_W         = 8;

   typedef enum logic [1:0] {
      OP_WRITE_START = 2'd0,
      OP_WRITE_BYTE  = 2'd1,
      OP_READ_START  = 2'd2,
      OP_READ_BYTE   = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_OK       = 3'd0,
      ST_NO_ROOM  = 3'd1,
      ST_EMPTY    = 3'd2,
      ST_TOO_LONG = 3'd3,
      ST_SEQUENCE = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      FSM_IDLE,
      FSM_WRITE_HDR,
      FSM_READ_HDR,
      FSM_READ_BYTE
   } fsm_type;

   typedef struct packed {
      logic [LEN_W-1:0] readable;
      logic [LEN_W-1:0] writable;
   } level_type;

endpackage

>>> src/lpmr_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port, single read port with registered read data.
// ----------------------------------------------------------------------------
module lpmr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> src/lpmr_level.sv
// ----------------------------------------------------------------------------
// Ring fill level
// Derives readable and writable byte counts from the committed positions.
// ----------------------------------------------------------------------------
module lpmr_level #(
   parameter int RING_BYTES = lpmr_pkg::RING_BYTES_DEF
) (
   input  logic [$clog2(RING_BYTES):0] wr_ptr,
   input  logic [$clog2(RING_BYTES):0] rd_ptr,
   output lpmr_pkg::level_type         level
);

   localparam int PW = $clog2(RING_BYTES) + 1;
   localparam int WW = (PW > lpmr_pkg::LEN_W) ? PW : lpmr_pkg::LEN_W;
   localparam int SAT = (1 << lpmr_pkg::LEN_W) - 1;

   logic [PW-1:0] used;
   logic [PW-1:0] readable_raw;
   logic [PW-1:0] writable_raw;
   logic [WW-1:0] readable_ext;
   logic [WW-1:0] writable_ext;

   always_comb begin
      used = wr_ptr - rd_ptr;
      if (used >= PW'(lpmr_pkg::HDR_BYTES)) begin
         readable_raw = used - PW'(lpmr_pkg::HDR_BYTES);
      end else begin
         readable_raw = '0;
      end
      if (used >= PW'(RING_BYTES - lpmr_pkg::HDR_BYTES)) begin
         writable_raw = '0;
      end else begin
         writable_raw = PW'(RING_BYTES - lpmr_pkg::HDR_BYTES) - used;
      end
      readable_ext = WW'(readable_raw);
      writable_ext = WW'(writable_raw);
      if (readable_ext > WW'(SAT)) begin
         level.readable = lpmr_pkg::LEN_W'(SAT);
      end else begin
         level.readable = readable_ext[lpmr_pkg::LEN_W-1:0];
      end
      if (writable_ext > WW'(SAT)) begin
         level.writable = lpmr_pkg::LEN_W'(SAT);
      end else begin
         level.writable = writable_ext[lpmr_pkg::LEN_W-1:0];
      end
   end

endmodule

>>> src/length_prefixed_message_ring_core.sv
// Timing: a result strobes in the cycle after acceptance for byte writes, empty write starts
// and refusals made without a header access. A byte read waits in READ_BYTE for the
// registered read data; a write start that stores a header or a read start that fetches
// one steps through WRITE_HDR or READ_HDR first. Busy holds off the next word; headers
// take four accesses on the byte-wide RAM port. The receiver cannot stall results.
// Reset: synchronous; positions, counts and the controller clear, the RAM keeps its data.
// ----------------------------------------------------------------------------
// Length-prefixed message ring core
// Byte ring of whole messages with four-byte little-endian length headers.
// ----------------------------------------------------------------------------
module length_prefixed_message_ring_core #(
   parameter int RING_BYTES = lpmr_pkg::RING_BYTES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_op,
   input  logic [11:0] req_msg_len,
   input  logic [7:0]  req_data_byte,
   input  logic        req_consume,
   output logic        rsp_valid,
   output logic [2:0]  rsp_status,
   output logic [11:0] rsp_out_len,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_last,
   output logic [11:0] rsp_readable_bytes,
   output logic [11:0] rsp_writable_bytes
);

   `include "length_prefixed_message_ring_core_assert.svh"

   localparam int AW = $clog2(RING_BYTES);
   localparam int PW = AW + 1;
   localparam int LW = lpmr_pkg::LEN_W;

   lpmr_pkg::fsm_type    state_ff, state_in;
   logic [2:0]           cnt_ff, cnt_in;
   logic [PW-1:0]        wp_ff, wp_in;
   logic [PW-1:0]        rp_ff, rp_in;
   logic [PW-1:0]        wc_ff, wc_in;
   logic [PW-1:0]        rc_ff, rc_in;
   logic [LW-1:0]        wl_ff, wl_in;
   logic [LW-1:0]        rl_ff, rl_in;
   logic                 removes_ff, removes_in;
   logic [LW-1:0]        len_ff, len_in;
   logic                 cons_ff, cons_in;
   logic [23:0]          hdr_ff, hdr_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   lpmr_pkg::status_type status_ff, status_in;
   logic [LW-1:0]        olen_ff, olen_in;
   logic [7:0]           obyte_ff, obyte_in;
   logic                 last_ff, last_in;

   logic                 accept;
   logic                 mem_we;
   logic [AW-1:0]        mem_waddr;
   logic [7:0]           mem_wdata;
   logic [AW-1:0]        mem_raddr;
   logic [7:0]           mem_rdata;
   logic [31:0]          hdr_full;
   logic [PW-1:0]        pos_tmp;
   lpmr_pkg::level_type  level;

   lpmr_ram #(
      .WIDTH (lpmr_pkg::BYTE_W),
      .DEPTH (RING_BYTES)
   ) u_ram (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   lpmr_level #(
      .RING_BYTES (RING_BYTES)
   ) u_level (
      .wr_ptr (wp_ff),
      .rd_ptr (rp_ff),
      .level  (level)
   );

   assign busy   = (state_ff != lpmr_pkg::FSM_IDLE);
   assign accept = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lpmr_pkg::FSM_IDLE;
         cnt_ff       <= '0;
         wp_ff        <= '0;
         rp_ff        <= '0;
         wc_ff        <= '0;
         rc_ff        <= '0;
         wl_ff        <= '0;
         rl_ff        <= '0;
         removes_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         wp_ff        <= wp_in;
         rp_ff        <= rp_in;
         wc_ff        <= wc_in;
         rc_ff        <= rc_in;
         wl_ff        <= wl_in;
         rl_ff        <= rl_in;
         removes_ff   <= removes_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      len_ff    <= len_in;
      cons_ff   <= cons_in;
      hdr_ff    <= hdr_in;
      status_ff <= status_in;
      olen_ff   <= olen_in;
      obyte_ff  <= obyte_in;
      last_ff   <= last_in;
   end

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      wp_in        = wp_ff;
      rp_in        = rp_ff;
      wc_in        = wc_ff;
      rc_in        = rc_ff;
      wl_in        = wl_ff;
      rl_in        = rl_ff;
      removes_in   = removes_ff;
      len_in       = len_ff;
      cons_in      = cons_ff;
      hdr_in       = hdr_ff;
      rsp_valid_in = 1'b0;
      status_in    = lpmr_pkg::ST_OK;
      olen_in      = '0;
      obyte_in     = '0;
      last_in      = 1'b0;
      mem_we       = 1'b0;
      mem_waddr    = wc_ff[AW-1:0];
      mem_wdata    = req_data_byte;
      mem_raddr    = rp_ff[AW-1:0];
      hdr_full     = {mem_rdata, hdr_ff};
      pos_tmp      = '0;

      case (state_ff)
         lpmr_pkg::FSM_IDLE: begin
            if (accept) begin
               case (lpmr_pkg::op_type'(req_op))
                  lpmr_pkg::OP_WRITE_START: begin
                     wl_in = '0;
                     if (req_msg_len == '0) begin
                        rsp_valid_in = 1'b1;
                     end else if (level.writable < req_msg_len) begin
                        rsp_valid_in = 1'b1;
                        status_in    = lpmr_pkg::ST_NO_ROOM;
                     end else begin
                        len_in   = req_msg_len;
                        cnt_in   = '0;
                        state_in = lpmr_pkg::FSM_WRITE_HDR;
                     end
                  end
                  lpmr_pkg::OP_WRITE_BYTE: begin
                     rsp_valid_in = 1'b1;
                     if (wl_ff == '0) begin
                        status_in = lpmr_pkg::ST_SEQUENCE;
                     end else begin
                        mem_we    = 1'b1;
                        mem_waddr = wc_ff[AW-1:0];
                        mem_wdata = req_data_byte;
                        wc_in     = wc_ff + PW'(1);
                        wl_in     = wl_ff - LW'(1);
                        if (wl_ff == LW'(1)) begin
                           last_in = 1'b1;
                           wp_in   = wc_ff + PW'(1);
                        end
                     end
                  end
                  lpmr_pkg::OP_READ_START: begin
                     rl_in = '0;
                     if (level.readable == '0) begin
                        rsp_valid_in = 1'b1;
                        status_in    = lpmr_pkg::ST_EMPTY;
                     end else begin
                        mem_raddr = rp_ff[AW-1:0];
                        len_in    = req_msg_len;
                        cons_in   = req_consume;
                        cnt_in    = 3'd1;
                        state_in  = lpmr_pkg::FSM_READ_HDR;
                     end
                  end
                  lpmr_pkg::OP_READ_BYTE: begin
                     if (rl_ff == '0) begin
                        rsp_valid_in = 1'b1;
                        status_in    = lpmr_pkg::ST_SEQUENCE;
                     end else begin
                        mem_raddr = rc_ff[AW-1:0];
                        state_in  = lpmr_pkg::FSM_READ_BYTE;
                     end
                  end
                  default: begin
                     state_in = lpmr_pkg::FSM_IDLE;
                  end
               endcase
            end
         end

         lpmr_pkg::FSM_WRITE_HDR: begin
            pos_tmp   = wp_ff + PW'(cnt_ff);
            mem_we    = 1'b1;
            mem_waddr = pos_tmp[AW-1:0];
            case (cnt_ff)
               3'd0:    mem_wdata = len_ff[7:0];
               3'd1:    mem_wdata = {4'h0, len_ff[11:8]};
               default: mem_wdata = '0;
            endcase
            if (cnt_ff == 3'd3) begin
               wc_in        = wp_ff + PW'(lpmr_pkg::HDR_BYTES);
               wl_in        = len_ff;
               rsp_valid_in = 1'b1;
               state_in     = lpmr_pkg::FSM_IDLE;
            end else begin
               cnt_in = cnt_ff + 3'd1;
            end
         end

         lpmr_pkg::FSM_READ_HDR: begin
            case (cnt_ff)
               3'd1:    hdr_in[7:0]   = mem_rdata;
               3'd2:    hdr_in[15:8]  = mem_rdata;
               3'd3:    hdr_in[23:16] = mem_rdata;
               default: hdr_in        = hdr_ff;
            endcase
            if (cnt_ff == 3'd4) begin
               rsp_valid_in = 1'b1;
               olen_in      = hdr_full[LW-1:0];
               state_in     = lpmr_pkg::FSM_IDLE;
               if ((hdr_full > 32'(RING_BYTES - lpmr_pkg::HDR_BYTES)) ||
                   (hdr_full > 32'(len_ff))) begin
                  status_in = lpmr_pkg::ST_TOO_LONG;
               end else begin
                  rc_in      = rp_ff + PW'(lpmr_pkg::HDR_BYTES);
                  removes_in = cons_ff;
                  rl_in      = hdr_full[LW-1:0];
                  if (hdr_full == '0) begin
                     last_in = 1'b1;
                     if (cons_ff) begin
                        rp_in = rp_ff + PW'(lpmr_pkg::HDR_BYTES);
                     end
                  end
               end
            end else begin
               pos_tmp   = rp_ff + PW'(cnt_ff);
               mem_raddr = pos_tmp[AW-1:0];
               cnt_in    = cnt_ff + 3'd1;
            end
         end

         lpmr_pkg::FSM_READ_BYTE: begin
            rsp_valid_in = 1'b1;
            obyte_in     = mem_rdata;
            rc_in        = rc_ff + PW'(1);
            rl_in        = rl_ff - LW'(1);
            state_in     = lpmr_pkg::FSM_IDLE;
            if (rl_ff == LW'(1)) begin
               last_in = 1'b1;
               if (removes_ff) begin
                  rp_in = rc_ff + PW'(1);
               end
            end
         end

         default: begin
            state_in = lpmr_pkg::FSM_IDLE;
         end
      endcase
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = status_ff;
   assign rsp_out_len        = olen_ff;
   assign rsp_out_byte       = obyte_ff;
   assign rsp_last           = last_ff;
   assign rsp_readable_bytes = level.readable;
   assign rsp_writable_bytes = level.writable;

   `LPMR_ASSERT_SAME(a_rsp_only_when_idle, clock, reset, rsp_valid, !busy,
      "Result word strobed while the controller is still busy")
   `LPMR_ASSERT_NEXT(a_accept_progress, clock, reset, accept, busy || rsp_valid,
      "Accepted word neither in progress nor answered")
   `LPMR_ASSERT_SAME(a_empty_level, clock, reset,
      rsp_valid && (rsp_status == lpmr_pkg::ST_EMPTY), rsp_readable_bytes == '0,
      "Empty status reported while bytes are readable")

endmodule

>>> tb/length_prefixed_message_ring_core_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Length-prefixed message ring core testbench
// Drives write and read words through the start/busy port and predicts every
// strobed result with a cycle-free model of the ring held in a scoreboard.
// A directed opening covers the status codes, abandoned starts, peeking and
// field extremes. Random message traffic follows under several idle patterns.
// ----------------------------------------------------------------------------
typedef struct packed {
   lpmr_pkg::status_type status;
   logic [11:0]          out_len;
   logic [7:0]           out_byte;
   logic                 last;
   logic [11:0]          readable_bytes;
   logic [11:0]          writable_bytes;
} ring_result_type;

class message_ring_tracker;
   bit [7:0]        ring_mem [lpmr_pkg::RING_BYTES_DEF];
   bit [31:0]       rd_pos;
   bit [31:0]       wr_pos;
   bit [31:0]       wr_cur;
   bit [31:0]       rd_cur;
   bit [11:0]       wr_left;
   bit [11:0]       rd_left;
   bit              rd_consume;
   ring_result_type expected_results[$];
   int              failures;

   function int addr_of(bit [31:0] pos);
      return int'(pos & (lpmr_pkg::RING_BYTES_DEF - 1));
   endfunction

   function bit [31:0] readable_count();
      bit [31:0] used;
      used = wr_pos - rd_pos;
      return (used >= lpmr_pkg::HDR_BYTES) ? used - lpmr_pkg::HDR_BYTES : 32'd0;
   endfunction

   function bit [31:0] writable_count();
      bit [31:0] used;
      bit [31:0] room;
      used = wr_pos - rd_pos;
      room = lpmr_pkg::RING_BYTES_DEF - lpmr_pkg::HDR_BYTES;
      return (used >= room) ? 32'd0 : room - used;
   endfunction

   function bit [11:0] clip12(bit [31:0] v);
      return (v > 32'hFFF) ? 12'hFFF : v[11:0];
   endfunction

   function void note_word(lpmr_pkg::op_type op, bit [11:0] len, bit [7:0] data,
                           bit consume);
      ring_result_type r;
      bit [31:0]       hdr_word;
      r.status   = lpmr_pkg::ST_OK;
      r.out_len  = '0;
      r.out_byte = '0;
      r.last     = 1'b0;
      case (op)
         lpmr_pkg::OP_WRITE_START: begin
            wr_left = '0;
            if (len != 0) begin
               if (writable_count() < len) begin
                  r.status = lpmr_pkg::ST_NO_ROOM;
               end else begin
                  hdr_word = {20'd0, len};
                  for (int i = 0; i < lpmr_pkg::HDR_BYTES; i++)
                     ring_mem[addr_of(wr_pos + i)] = hdr_word[8*i +: 8];
                  wr_cur  = wr_pos + lpmr_pkg::HDR_BYTES;
                  wr_left = len;
               end
            end
         end
         lpmr_pkg::OP_WRITE_BYTE: begin
            if (wr_left == 0) begin
               r.status = lpmr_pkg::ST_SEQUENCE;
            end else begin
               ring_mem[addr_of(wr_cur)] = data;
               wr_cur++;
               wr_left--;
               if (wr_left == 0) begin
                  r.last = 1'b1;
                  wr_pos = wr_cur;
               end
            end
         end
         lpmr_pkg::OP_READ_START: begin
            rd_left = '0;
            if (readable_count() == 0) begin
               r.status = lpmr_pkg::ST_EMPTY;
            end else begin
               hdr_word = '0;
               for (int i = 0; i < lpmr_pkg::HDR_BYTES; i++)
                  hdr_word[8*i +: 8] = ring_mem[addr_of(rd_pos + i)];
               r.out_len = hdr_word[11:0];
               if (hdr_word > lpmr_pkg::RING_BYTES_DEF - lpmr_pkg::HDR_BYTES ||
                   hdr_word > len) begin
                  r.status = lpmr_pkg::ST_TOO_LONG;
               end else begin
                  rd_cur     = rd_pos + lpmr_pkg::HDR_BYTES;
                  rd_consume = consume;
                  rd_left    = hdr_word[11:0];
                  if (hdr_word == 0) begin
                     r.last = 1'b1;
                     if (consume)
                        rd_pos = rd_cur;
                  end
               end
            end
         end
         default: begin
            if (rd_left == 0) begin
               r.status = lpmr_pkg::ST_SEQUENCE;
            end else begin
               r.out_byte = ring_mem[addr_of(rd_cur)];
               rd_cur++;
               rd_left--;
               if (rd_left == 0) begin
                  r.last = 1'b1;
                  if (rd_consume)
                     rd_pos = rd_cur;
               end
            end
         end
      endcase
      r.readable_bytes = clip12(readable_count());
      r.writable_bytes = clip12(writable_count());
      expected_results.push_back(r);
   endfunction

   function void check_result(ring_result_type got);
      ring_result_type want;
      if (expected_results.size() == 0) begin
         $error("unexpected result with status %0d", got.status);
         failures++;
         return;
      end
      want = expected_results.pop_front();
      if (got.status !== want.status) begin
         $error("status expected %0d got %0d", want.status, got.status);
         failures++;
      end
      if (got.out_len !== want.out_len) begin
         $error("out_len expected %0d got %0d", want.out_len, got.out_len);
         failures++;
      end
      if (got.out_byte !== want.out_byte) begin
         $error("out_byte expected %0d got %0d", want.out_byte, got.out_byte);
         failures++;
      end
      if (got.last !== want.last) begin
         $error("last expected %0d got %0d", want.last, got.last);
         failures++;
      end
      if (got.readable_bytes !== want.readable_bytes) begin
         $error("readable_bytes expected %0d got %0d", want.readable_bytes,
                got.readable_bytes);
         failures++;
      end
      if (got.writable_bytes !== want.writable_bytes) begin
         $error("writable_bytes expected %0d got %0d", want.writable_bytes,
                got.writable_bytes);
         failures++;
      end
   endfunction
endclass

module length_prefixed_message_ring_core_test;
   localparam int QUIET_LIMIT = 4000;
   localparam int PHASE_WORDS = 463;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [1:0]  req_op = lpmr_pkg::OP_WRITE_START;
   logic [11:0] req_msg_len = '0;
   logic [7:0]  req_data_byte = '0;
   logic        req_consume = 1'b0;
   logic        rsp_valid;
   logic [2:0]  rsp_status;
   logic [11:0] rsp_out_len;
   logic [7:0]  rsp_out_byte;
   logic        rsp_last;
   logic [11:0] rsp_readable_bytes;
   logic [11:0] rsp_writable_bytes;

   message_ring_tracker tracker = new();
   int                  sender_idle_pct = 0;
   int                  quiet_cycles = 0;
   int                  phase_idle [4] = '{0, 69, 0, 30};

   length_prefixed_message_ring_core dut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_op             (req_op),
      .req_msg_len        (req_msg_len),
      .req_data_byte      (req_data_byte),
      .req_consume        (req_consume),
      .rsp_valid          (rsp_valid),
      .rsp_status         (rsp_status),
      .rsp_out_len        (rsp_out_len),
      .rsp_out_byte       (rsp_out_byte),
      .rsp_last           (rsp_last),
      .rsp_readable_bytes (rsp_readable_bytes),
      .rsp_writable_bytes (rsp_writable_bytes)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      ring_result_type got;
      if (!reset && rsp_valid === 1'b1) begin
         got.status         = lpmr_pkg::status_type'(rsp_status);
         got.out_len        = rsp_out_len;
         got.out_byte       = rsp_out_byte;
         got.last           = rsp_last;
         got.readable_bytes = rsp_readable_bytes;
         got.writable_bytes = rsp_writable_bytes;
         tracker.check_result(got);
      end
   end

   always @(posedge clock) begin
      if ((start && busy === 1'b0) || rsp_valid === 1'b1)
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("length_prefixed_message_ring_core: mismatch");
         $finish;
      end
   end

   task automatic send_word(lpmr_pkg::op_type op, logic [11:0] len, logic [7:0] data,
                            logic consume);
      while ($urandom_range(99) < sender_idle_pct) begin
         @(negedge clock);
         start <= 1'b0;
      end
      @(negedge clock);
      start         <= 1'b1;
      req_op        <= op;
      req_msg_len   <= len;
      req_data_byte <= data;
      req_consume   <= consume;
      do
         @(posedge clock);
      while (busy !== 1'b0);
      tracker.note_word(op, len, data, consume);
   endtask

   task automatic drain_results();
      @(negedge clock);
      start <= 1'b0;
      while (tracker.expected_results.size() != 0)
         @(posedge clock);
   endtask

   function automatic logic [11:0] message_length();
      int r;
      r = $urandom_range(99);
      if (r < 4)
         return 12'd0;
      else if (r < 80)
         return 12'($urandom_range(8, 1));
      else if (r < 95)
         return 12'($urandom_range(64, 9));
      else if (r < 99)
         return 12'($urandom_range(600, 65));
      else
         return 12'($urandom_range(4092, 601));
   endfunction

   function automatic logic [11:0] read_limit();
      int r;
      r = $urandom_range(99);
      if (r < 70)
         return 12'd4092;
      else if (r < 90)
         return 12'($urandom_range(4092));
      else
         return 12'($urandom_range(7));
   endfunction

   task automatic random_word();
      int               pick;
      bit [31:0]        ready;
      lpmr_pkg::op_type op;
      logic [11:0]      len;
      logic [7:0]       data;
      logic             consume;
      pick    = $urandom_range(99);
      ready   = tracker.readable_count();
      len     = 12'($urandom_range(4092));
      data    = 8'($urandom_range(255));
      consume = 1'($urandom_range(1));
      if (pick < 3) begin
         op = lpmr_pkg::op_type'($urandom_range(3));
      end else if (tracker.wr_left != 0 && (tracker.rd_left == 0 || pick < 55)) begin
         if ($urandom_range(99) < ((tracker.wr_left > 64) ? 10 : 2)) begin
            op  = lpmr_pkg::OP_WRITE_START;
            len = message_length();
         end else begin
            op = lpmr_pkg::OP_WRITE_BYTE;
         end
      end else if (tracker.rd_left != 0) begin
         if ($urandom_range(99) < 3) begin
            op  = lpmr_pkg::OP_READ_START;
            len = read_limit();
         end else begin
            op = lpmr_pkg::OP_READ_BYTE;
         end
      end else if ((ready != 0 && (pick < 52 || ready > 600)) || (ready == 0 && pick < 8)) begin
         op      = lpmr_pkg::OP_READ_START;
         len     = read_limit();
         consume = ($urandom_range(99) < 80);
      end else begin
         op  = lpmr_pkg::OP_WRITE_START;
         len = message_length();
      end
      send_word(op, len, data, consume);
   endtask

   initial begin
      repeat (7) @(negedge clock);
      reset <= 1'b0;

      send_word(lpmr_pkg::OP_READ_START, 12'd4092, 8'h00, 1'b1);
      send_word(lpmr_pkg::OP_READ_BYTE, 12'd0, 8'h00, 1'b0);
      send_word(lpmr_pkg::OP_WRITE_BYTE, 12'd0, 8'hFF, 1'b0);
      send_word(lpmr_pkg::OP_WRITE_START, 12'd0, 8'h00, 1'b0);
      send_word(lpmr_pkg::OP_WRITE_BYTE, 12'd4092, 8'h3C, 1'b1);
      send_word(lpmr_pkg::OP_WRITE_START, 12'd4092, 8'h00, 1'b0);
      send_word(lpmr_pkg::OP_WRITE_START, 12'd3, 8'h00, 1'b1);
      send_word(lpmr_pkg::OP_WRITE_BYTE, 12'd0, 8'h00, 1'b0);
      send_word(lpmr_pkg::OP_WRITE_BYTE, 12'd0, 8'hFF, 1'b0);
      send_word(lpmr_pkg::OP_WRITE_BYTE, 12'd0, 8'hA5, 1'b0);
      send_word(lpmr_pkg::OP_WRITE_START, 12'd4092, 8'h00, 1'b0);
      send_word(lpmr_pkg::OP_READ_START, 12'd2, 8'h00, 1'b1);
      send_word(lpmr_pkg::OP_READ_START, 12'd3, 8'h00, 1'b0);
      send_word(lpmr_pkg::OP_READ_BYTE, 12'd0, 8'h00, 1'b0);
      send_word(lpmr_pkg::OP_READ_START, 12'd4091, 8'h00, 1'b1);
      send_word(lpmr_pkg::OP_READ_BYTE, 12'd0, 8'h00, 1'b0);
      send_word(lpmr_pkg::OP_READ_BYTE, 12'd0, 8'h00, 1'b0);
      send_word(lpmr_pkg::OP_READ_BYTE, 12'd0, 8'h00, 1'b0);
      send_word(lpmr_pkg::OP_READ_START, 12'd4092, 8'h00, 1'b1);
      send_word(lpmr_pkg::OP_WRITE_START, 12'd1, 8'h00, 1'b0);
      send_word(lpmr_pkg::OP_WRITE_BYTE, 12'd0, 8'h5A, 1'b0);
      send_word(lpmr_pkg::OP_READ_START, 12'd1, 8'h00, 1'b1);
      send_word(lpmr_pkg::OP_READ_BYTE, 12'd0, 8'h00, 1'b0);
      drain_results();

      for (int phase = 0; phase < 4; phase++) begin
         sender_idle_pct = phase_idle[phase];
         for (int n = 0; n < PHASE_WORDS; n++)
            random_word();
         drain_results();
      end

      repeat (8) @(posedge clock);
      if (tracker.expected_results.size() != 0) begin
         $error("%0d results never arrived", tracker.expected_results.size());
         tracker.failures++;
      end
      if (tracker.failures == 0)
         $display("length_prefixed_message_ring_core: match");
      else
         $display("length_prefixed_message_ring_core: mismatch");
      $finish;
   end
endmodule
